// File: rtl/core/assert_macros.svh
// Assertion macros for the checker file.
// Depends on clk_i and rst_ni being visible in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every rising clock edge, suspended while reset is asserted.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check on every rising clock edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: rtl/core/mdsd_pkg.sv
// Shared types, constants and the segment decode for the display driver.
// No dependencies; used by the channel interfaces, imported by every module but the checker.
`timescale 1ns / 1ps

package mdsd_pkg;

  localparam int unsigned ValueW = 20;
  localparam int unsigned DigitW = 10;   // scaled value, below 1000 unless over range
  localparam int unsigned NumDigits = 3;
  localparam int unsigned ScanW = 2;
  localparam int unsigned SegW = 7;

  localparam logic [ValueW-1:0] OverLimit  = 20'd100000;
  localparam logic [ValueW-1:0] ThreeLimit = 20'd10000;
  localparam logic [ValueW-1:0] TwoLimit   = 20'd1000;

  // Reciprocals for v / 100 and v / 10, exact for v below 100000
  localparam int unsigned MulW = 18;
  localparam int unsigned ProdW = 35;
  localparam logic [MulW-1:0] Div100Mul = 18'd167773;  // 2^24 / 100, rounded up
  localparam logic [MulW-1:0] Div10Mul  = 18'd104858;  // 2^20 / 10, rounded up
  localparam int unsigned Div100Shift = 24;
  localparam int unsigned Div10Shift  = 20;

  localparam logic [3:0] CodeBlank = 4'd10;

  typedef enum logic [1:0] {
    OP_SET  = 2'd0,
    OP_TICK = 2'd1,
    OP_ON   = 2'd2,
    OP_OFF  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    RNG_ONE   = 2'd0,
    RNG_TWO   = 2'd1,
    RNG_THREE = 2'd2,
    RNG_OVER  = 2'd3
  } rng_e;

  // Registered item as seen by the core
  typedef struct packed {
    logic              valid;
    op_e               op;
    rng_e              rng;
    logic [DigitW-1:0] scaled;
  } stage_t;

  // Digit cell: point flag above a four-bit digit code
  typedef struct packed {
    logic       point;
    logic [3:0] code;
  } cell_t;

  // Lit-segment mask, segment a in bit 0; codes above nine are blank
  function automatic logic [SegW-1:0] seg_lit_f(input logic [3:0] code);
    logic [SegW-1:0] lit;
    case (code)
      4'd0:    lit = 7'h3F;
      4'd1:    lit = 7'h06;
      4'd2:    lit = 7'h5B;
      4'd3:    lit = 7'h4F;
      4'd4:    lit = 7'h66;
      4'd5:    lit = 7'h6D;
      4'd6:    lit = 7'h7D;
      4'd7:    lit = 7'h07;
      4'd8:    lit = 7'h7F;
      4'd9:    lit = 7'h6F;
      default: lit = 7'h00;
    endcase
    return lit;
  endfunction

endpackage

// File: rtl/core/mdsd_if.sv
// Valid/ready channel interfaces for the display driver: items in, pin drive out.
// Depends on mdsd_pkg for the op type and field widths.
`timescale 1ns / 1ps

interface mdsd_in_if;
  logic                              valid;
  logic                              ready;
  mdsd_pkg::op_e                     op;
  logic [mdsd_pkg::ValueW-1:0]       value_hundredths;

  modport source (output valid, output op, output value_hundredths, input ready);
  modport sink (input valid, input op, input value_hundredths, output ready);
  modport monitor (input valid, input op, input value_hundredths, input ready);
endinterface

interface mdsd_out_if;
  logic                              valid;
  logic                              ready;
  logic [mdsd_pkg::SegW-1:0]         segment_lines;
  logic                              point_line;
  logic [mdsd_pkg::NumDigits-1:0]    digit_enables;

  modport source (output valid, output segment_lines, output point_line,
                  output digit_enables, input ready);
  modport sink (input valid, input segment_lines, input point_line,
                input digit_enables, output ready);
  modport monitor (input valid, input segment_lines, input point_line,
                   input digit_enables, input ready);
endinterface

// File: rtl/core/mdsd_in_stage.sv
// Input register with range classification and scaling of the set value.
// Depends on mdsd_pkg and mdsd_in_if.
`timescale 1ns / 1ps

module mdsd_in_stage (
  input  logic             clk_i,
  input  logic             rst_ni,
  mdsd_in_if.sink          in_i,
  input  logic             advance_i,
  output mdsd_pkg::stage_t stage_o
);
  import mdsd_pkg::*;

  logic                  valid_q;
  op_e                   op_q;
  rng_e                  rng_q, rng_d;
  logic [DigitW-1:0]     scaled_q, scaled_d;
  logic [16:0]           v17;
  logic [MulW-1:0]       mul;
  logic [ProdW-1:0]      prod;
  logic                  load;

  assign load = in_i.valid && in_i.ready;
  assign in_i.ready = !valid_q || advance_i;

  // Bring the value into the range 0..999 ahead of the digit split, unless over range
  always_comb begin
    v17 = in_i.value_hundredths[16:0];
    if (in_i.value_hundredths >= OverLimit) begin
      rng_d = RNG_OVER;
    end else if (in_i.value_hundredths >= ThreeLimit) begin
      rng_d = RNG_THREE;
    end else if (in_i.value_hundredths >= TwoLimit) begin
      rng_d = RNG_TWO;
    end else begin
      rng_d = RNG_ONE;
    end
    mul  = (rng_d == RNG_THREE) ? Div100Mul : Div10Mul;
    prod = {{(ProdW-17){1'b0}}, v17} * {{(ProdW-MulW){1'b0}}, mul};
    case (rng_d)
      RNG_THREE: scaled_d = prod[Div100Shift +: DigitW];
      RNG_TWO:   scaled_d = prod[Div10Shift +: DigitW];
      default:   scaled_d = in_i.value_hundredths[DigitW-1:0];
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_i.ready) begin
      valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      op_q     <= in_i.op;
      rng_q    <= rng_d;
      scaled_q <= scaled_d;
    end
  end

  assign stage_o = '{valid: valid_q, op: op_q, rng: rng_q, scaled: scaled_q};

endmodule

// File: rtl/core/mdsd_core.sv
// Digit cells, scan state and the registered pin drive that forms the result.
// Depends on mdsd_pkg and mdsd_out_if.
`timescale 1ns / 1ps

module mdsd_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  mdsd_pkg::stage_t stage_i,
  output logic             advance_o,
  mdsd_out_if.source       out_o
);
  import mdsd_pkg::*;

  localparam int unsigned DriveW = SegW + 1 + NumDigits;
  localparam logic [DriveW-1:0] DriveReset = 11'h0FF;
  localparam logic [ScanW-1:0] LastPos = ScanW'(NumDigits - 1);

  cell_t               cells_q [NumDigits];
  cell_t               cells_d [NumDigits];
  logic [ScanW-1:0]    scan_q, scan_d;
  logic                on_q, on_d;
  logic [DriveW-1:0]   drive_q, drive_d;
  logic                out_valid_q;

  logic [3:0]          hund, tens, units;
  logic [DigitW-1:0]   rem_h;
  logic [6:0]          rem_t;
  logic [ScanW-1:0]    pos;
  cell_t               cur;

  assign advance_o = stage_i.valid && (!out_valid_q || out_o.ready);

  // Split the scaled value into three decimal digits by compare and subtract
  always_comb begin
    hund = 4'd0;
    for (int i = 1; i < 10; i++) begin
      if (stage_i.scaled >= DigitW'(i * 100)) begin
        hund = 4'(i);
      end
    end
    rem_h = stage_i.scaled - DigitW'({6'd0, hund} * DigitW'(100));
    rem_t = rem_h[6:0];
    tens = 4'd0;
    for (int i = 1; i < 10; i++) begin
      if (rem_t >= 7'(i * 10)) begin
        tens = 4'(i);
      end
    end
    units = 4'(rem_t - 7'({3'd0, tens} * 7'd10));
  end

  always_comb begin
    cells_d = cells_q;
    scan_d  = scan_q;
    on_d    = on_q;
    drive_d = drive_q;
    pos     = (scan_q > LastPos) ? '0 : scan_q;
    cur     = cells_q[pos];
    case (stage_i.op)
      OP_SET: begin
        case (stage_i.rng)
          RNG_OVER: begin
            for (int i = 0; i < NumDigits; i++) begin
              cells_d[i] = '{point: 1'b1, code: CodeBlank};
            end
          end
          RNG_THREE: begin
            cells_d[0] = '{point: 1'b0, code: hund};
            cells_d[1] = '{point: 1'b0, code: tens};
            cells_d[2] = '{point: 1'b0, code: units};
          end
          RNG_TWO: begin
            cells_d[0] = '{point: 1'b0, code: hund};
            cells_d[1] = '{point: 1'b1, code: tens};
            cells_d[2] = '{point: 1'b0, code: units};
          end
          default: begin
            cells_d[0] = '{point: 1'b1, code: hund};
            cells_d[1] = '{point: 1'b0, code: tens};
            cells_d[2] = '{point: 1'b0, code: units};
          end
        endcase
      end
      OP_TICK: begin
        if (on_q) begin
          drive_d = {NumDigits'(1) << pos, !cur.point, ~seg_lit_f(cur.code)};
          scan_d  = (pos == LastPos) ? '0 : pos + ScanW'(1);
        end
      end
      OP_ON: begin
        on_d = 1'b1;
      end
      default: begin
        // Drive every line low and stop the scan
        drive_d = '0;
        on_d    = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumDigits; i++) begin
        cells_q[i] <= '{point: 1'b0, code: 4'd0};
      end
      scan_q      <= '0;
      on_q        <= 1'b1;
      drive_q     <= DriveReset;
      out_valid_q <= 1'b0;
    end else begin
      if (advance_o) begin
        cells_q <= cells_d;
        scan_q  <= scan_d;
        on_q    <= on_d;
        drive_q <= drive_d;
      end
      if (advance_o) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Pin drive only changes when a transaction moves into the result slot
  assign out_o.valid         = out_valid_q;
  assign out_o.segment_lines = drive_q[SegW-1:0];
  assign out_o.point_line    = drive_q[SegW];
  assign out_o.digit_enables = drive_q[DriveW-1 -: NumDigits];

endmodule

// File: rtl/core/muxed_three_digit_seven_segment_driver_top.sv
// Top level of the three-digit multiplexed seven-segment display driver.
// Depends on mdsd_pkg, mdsd_if, mdsd_in_stage and mdsd_core.
//
// Usage:
//   in_i carries one command per transaction: op selects set value, scan
//   tick, scan on or display off; value_hundredths is read by set only.
//   out_o returns one transaction per command: the pin drive after it,
//   cathodes segment_lines and point_line (low lights), and the one-hot
//   anode enables digit_enables (bit 0 is the leftmost digit).
//   A command passes through the input register, then the digit split and
//   state update feeding the result register, before its result is valid;
//   one command is taken every cycle while out_o is not stalled.
//   While out_o is stalled, one more command is taken into the input
//   register; after that in_i.ready stays low until the result is taken.
//   Reset clears both registers' valid flags, shows digit zero without
//   points in every cell, restarts the scan at the leftmost digit with
//   scanning enabled, and presets the drive to cathodes high, anodes off.
`timescale 1ns / 1ps

module muxed_three_digit_seven_segment_driver_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  mdsd_in_if.sink     in_i,
  mdsd_out_if.source  out_o
);
  import mdsd_pkg::*;

  stage_t stage;
  logic   advance;

  mdsd_in_stage u_in_stage (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .advance_i (advance),
    .stage_o   (stage)
  );

  mdsd_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .stage_i   (stage),
    .advance_o (advance),
    .out_o     (out_o)
  );

endmodule

// File: rtl/core/mdsd_checker.sv
// Port-level checks for the display driver, bound to the top level.
// Depends on mdsd_if and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mdsd_checker (
  input logic         clk_i,
  input logic         rst_ni,
  mdsd_in_if.sink     in_i,
  mdsd_out_if.source  out_o
);

  `ASSERT_CLK(a_out_valid_hold, out_o.valid && !out_o.ready |=> out_o.valid, "result dropped while stalled")

  `ASSERT_CLK(a_out_data_hold, out_o.valid && !out_o.ready |=> $stable(out_o.segment_lines) && $stable(out_o.point_line) && $stable(out_o.digit_enables), "result changed while stalled")

  `ASSERT_CLK(a_one_anode, out_o.valid |-> $onehot0(out_o.digit_enables), "more than one anode driven")

  `ASSERT_CLK(a_dark_pattern, out_o.valid && (out_o.digit_enables == 3'd0) |-> (out_o.segment_lines == 7'h7F && out_o.point_line) || (out_o.segment_lines == 7'h00 && !out_o.point_line), "no anode driven but cathodes not in reset or off pattern")

  `ASSERT_CLK(a_latency, $rose(out_o.valid) |-> $past(in_i.valid && in_i.ready, 2), "result appeared without a transaction two cycles earlier")

endmodule

bind muxed_three_digit_seven_segment_driver_top mdsd_checker u_mdsd_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .in_i   (in_i),
  .out_o  (out_o)
);
